[hdl/giu_pkg.sv]
// ----------------------------------------------------------------------------
// Grayscale image upscaler package
// Shared field widths, operation codes and register indexes.
// ----------------------------------------------------------------------------
package giu_pkg;

  // Field widths of the input, result and configuration beats.
  localparam int OP_W        = 1;
  localparam int LOAD_COL_W  = 7;
  localparam int LOAD_ROW_W  = 7;
  localparam int PIX_W       = 8;
  localparam int OUT_COORD_W = 10;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 18;
  localparam int SRC_DIM_W   = 8;
  localparam int OUT_DIM_W   = 11;
  localparam int STEP_W      = 18;

  // Coordinate times step, exact.
  localparam int POS_W       = OUT_COORD_W + STEP_W;
  // Compare width for output coordinates against the output size limit.
  localparam int OUT_CMP_W   = 14;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef enum logic {
    MODE_NEAREST  = 1'b0,
    MODE_BILINEAR = 1'b1
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE       = 3'd0,
    CFG_SRC_WIDTH  = 3'd1,
    CFG_SRC_HEIGHT = 3'd2,
    CFG_OUT_WIDTH  = 3'd3,
    CFG_OUT_HEIGHT = 3'd4,
    CFG_STEP_X     = 3'd5,
    CFG_STEP_Y     = 3'd6
  } cfg_idx_t;

  localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 8'd100;
  localparam logic [OUT_DIM_W-1:0] OUT_DIM_RESET = 11'd250;
  localparam logic [STEP_W-1:0]    STEP_RESET    = 18'd26214;

endpackage

[hdl/giu_if.sv]
// ----------------------------------------------------------------------------
// Grayscale image upscaler channels
// Valid/ready interfaces for the request beats and the pixel result beats.
// ----------------------------------------------------------------------------
interface giu_in_if import giu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [LOAD_COL_W-1:0]  load_column;
  logic [LOAD_ROW_W-1:0]  load_row;
  logic [PIX_W-1:0]       load_value;
  logic [OUT_COORD_W-1:0] out_column;
  logic [OUT_COORD_W-1:0] out_row;

  modport source (
    output valid, operation, load_column, load_row, load_value, out_column, out_row,
    input  ready
  );
  modport sink (
    input  valid, operation, load_column, load_row, load_value, out_column, out_row,
    output ready
  );
endinterface

interface giu_out_if import giu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;

  modport source (output valid, pixel_out, input ready);
  modport sink   (input valid, pixel_out, output ready);
endinterface

[hdl/grayscale_image_upscaler_core.sv]
// ----------------------------------------------------------------------------
// Grayscale image upscaler core
// Holds a source image in four parity banks and returns one scaled output
// pixel per compute beat, nearest neighbor or bilinear.
// ----------------------------------------------------------------------------
// Usage: in_chan carries load beats (write one source pixel) and compute beats
// (ask for one output pixel); out_chan returns one pixel per compute beat, in
// order, and nothing for a load. The configuration port writes mode, sizes and
// the Q16 steps; the user must write it only while no beat is in flight, which
// the block does not enforce. A compute beat passes the stage 1, 2, 3 and output
// registers. Throughput: one beat per cycle, loads and computes mixed, unstalled.
// The source image is split over four memories by column and row parity, so
// the four bilinear neighbors are always read together, one read per bank.
// A load writes its bank at the same pipeline point where computes read, so
// a compute sees every load accepted before it.
// Reset clears the pipeline and the configuration registers; the image store
// is not cleared and holds garbage until loaded.
// When out_chan stalls, the result holds in the output register and the
// pipeline keeps accepting beats until its four stages are full.
// ----------------------------------------------------------------------------
module grayscale_image_upscaler_core
  import giu_pkg::*;
#(
  parameter int SOURCE_DIM    = 128,
  parameter int OUTPUT_DIM    = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  giu_in_if.sink                in_chan,
  giu_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int HALF       = (SOURCE_DIM + 1) / 2;
  localparam int HALF_W     = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int PX_W       = POS_W - FRACTION_BITS;
  localparam int CMP_W      = PX_W + 1;
  localparam int ONE_W      = FRACTION_BITS + 1;
  localparam int WGT_W      = 2 * FRACTION_BITS + 1;
  localparam int PROD_W     = WGT_W + PIX_W;
  localparam int SUM_W      = PROD_W + 2;

  localparam logic [ONE_W-1:0] ONE    = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [WGT_W-1:0] ONE_SQ = {1'b1, {(2 * FRACTION_BITS){1'b0}}};

  // Configuration registers.
  mode_t                mode_r;
  logic [SRC_DIM_W-1:0] src_w_r, src_h_r;
  logic [OUT_DIM_W-1:0] out_w_r, out_h_r;
  logic [STEP_W-1:0]    step_x_r, step_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_BILINEAR;
      src_w_r  <= SRC_DIM_RESET;
      src_h_r  <= SRC_DIM_RESET;
      out_w_r  <= OUT_DIM_RESET;
      out_h_r  <= OUT_DIM_RESET;
      step_x_r <= STEP_RESET;
      step_y_r <= STEP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MODE:       mode_r   <= mode_t'(cfg_data[0]);
        CFG_SRC_WIDTH:  src_w_r  <= cfg_data[SRC_DIM_W-1:0];
        CFG_SRC_HEIGHT: src_h_r  <= cfg_data[SRC_DIM_W-1:0];
        CFG_OUT_WIDTH:  out_w_r  <= cfg_data[OUT_DIM_W-1:0];
        CFG_OUT_HEIGHT: out_h_r  <= cfg_data[OUT_DIM_W-1:0];
        CFG_STEP_X:     step_x_r <= cfg_data[STEP_W-1:0];
        CFG_STEP_Y:     step_y_r <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage enables: a stage moves when the one after it is empty or moving.
  logic v1_r, v2_r, v3_r, out_v_r;
  logic en1, en2, en3, en4;

  assign en4 = !out_v_r || out_chan.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_chan.ready = en1;

  // Stage 1: accepted beat, with the source position already multiplied out.
  op_t                    s1_op_r;
  logic [LOAD_COL_W-1:0]  s1_col_r;
  logic [LOAD_ROW_W-1:0]  s1_row_r;
  logic [PIX_W-1:0]       s1_val_r;
  logic [OUT_COORD_W-1:0] s1_oc_r, s1_or_r;
  logic [POS_W-1:0]       s1_posx_r, s1_posy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_chan.valid) begin
      s1_op_r   <= op_t'(in_chan.operation);
      s1_col_r  <= in_chan.load_column;
      s1_row_r  <= in_chan.load_row;
      s1_val_r  <= in_chan.load_value;
      s1_oc_r   <= in_chan.out_column;
      s1_or_r   <= in_chan.out_row;
      s1_posx_r <= POS_W'(in_chan.out_column) * POS_W'(step_x_r);
      s1_posy_r <= POS_W'(in_chan.out_row) * POS_W'(step_y_r);
    end
  end

  // Stage 1 decode: integer and fraction parts, border test, load range.
  logic [PX_W-1:0]          px, py;
  logic [FRACTION_BITS-1:0] fx, fy;
  logic [ONE_W-1:0]         gx, gy;
  logic [CMP_W-1:0]         px_c, py_c, sw_c, sh_c, sw_eff, sh_eff;
  logic [OUT_CMP_W-1:0]     oc_c, or_c, ow_c, oh_c, ow_eff, oh_eff;
  logic                     zero_near, zero_bil, s2_zero_nxt;
  logic                     load_ok, load_go;

  assign px = s1_posx_r[POS_W-1:FRACTION_BITS];
  assign py = s1_posy_r[POS_W-1:FRACTION_BITS];
  assign fx = s1_posx_r[FRACTION_BITS-1:0];
  assign fy = s1_posy_r[FRACTION_BITS-1:0];
  assign gx = ONE - {1'b0, fx};
  assign gy = ONE - {1'b0, fy};

  assign px_c   = CMP_W'(px);
  assign py_c   = CMP_W'(py);
  assign sw_c   = CMP_W'(src_w_r);
  assign sh_c   = CMP_W'(src_h_r);
  assign sw_eff = (sw_c > CMP_W'(SOURCE_DIM)) ? CMP_W'(SOURCE_DIM) : sw_c;
  assign sh_eff = (sh_c > CMP_W'(SOURCE_DIM)) ? CMP_W'(SOURCE_DIM) : sh_c;

  assign oc_c   = OUT_CMP_W'(s1_oc_r);
  assign or_c   = OUT_CMP_W'(s1_or_r);
  assign ow_c   = OUT_CMP_W'(out_w_r);
  assign oh_c   = OUT_CMP_W'(out_h_r);
  assign ow_eff = (ow_c > OUT_CMP_W'(OUTPUT_DIM)) ? OUT_CMP_W'(OUTPUT_DIM) : ow_c;
  assign oh_eff = (oh_c > OUT_CMP_W'(OUTPUT_DIM)) ? OUT_CMP_W'(OUTPUT_DIM) : oh_c;

  assign zero_near = (oc_c >= ow_eff) || (or_c >= oh_eff) ||
                     (px_c >= sw_eff) || (py_c >= sh_eff);
  assign zero_bil  = (oc_c + OUT_CMP_W'(1) >= ow_eff) || (or_c + OUT_CMP_W'(1) >= oh_eff) ||
                     (px_c + CMP_W'(1) >= sw_eff) || (py_c + CMP_W'(1) >= sh_eff);
  assign s2_zero_nxt = (mode_r == MODE_NEAREST) ? zero_near : zero_bil;

  assign load_ok = (32'(s1_col_r) < 32'(SOURCE_DIM)) && (32'(s1_row_r) < 32'(SOURCE_DIM));
  assign load_go = en2 && v1_r && (s1_op_r == OP_LOAD) && load_ok;

  // Stage 2 and 3 registers, one lane per bank.
  logic             s2_zero_r, s3_zero_r;
  logic [WGT_W-1:0] s2_wgt_r  [4];
  logic [PIX_W-1:0] s2_pix_r  [4];
  logic [PROD_W-1:0] s3_prod_r [4];

  // Bank index: bit 0 is the column parity, bit 1 the row parity. A bank's
  // weight and address depend on whether it holds the pixel at the integer
  // position or its right or lower neighbor.
  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic CPAR = b[0];
    localparam logic RPAR = b[1];

    logic [PIX_W-1:0]   mem [BANK_DEPTH];
    logic               xsel, ysel, wen;
    logic [ONE_W-1:0]   wx, wy;
    logic [2*ONE_W-1:0] wprod;
    logic [WGT_W-1:0]   wgt_nxt;
    logic [HALF_W-1:0]  col_a, row_a;
    logic [BANK_AW-1:0] raddr, waddr;

    assign xsel  = (px[0] == CPAR);
    assign ysel  = (py[0] == RPAR);
    assign wx    = xsel ? gx : {1'b0, fx};
    assign wy    = ysel ? gy : {1'b0, fy};
    assign wprod = wx * wy;

    always_comb begin
      if (mode_r == MODE_NEAREST) begin
        wgt_nxt = (xsel && ysel) ? ONE_SQ : '0;
      end else begin
        wgt_nxt = WGT_W'(wprod);
      end
    end

    // An even bank serves column px+1 when px is odd, one half-step on.
    assign col_a = HALF_W'(px >> 1) + (CPAR ? '0 : HALF_W'(px[0]));
    assign row_a = HALF_W'(py >> 1) + (RPAR ? '0 : HALF_W'(py[0]));
    assign raddr = {row_a, col_a};
    assign waddr = {HALF_W'(s1_row_r >> 1), HALF_W'(s1_col_r >> 1)};
    assign wen   = load_go && (s1_col_r[0] == CPAR) && (s1_row_r[0] == RPAR);

    always_ff @(posedge clk) begin
      if (wen) begin
        mem[waddr] <= s1_val_r;
      end
      if (en2) begin
        s2_pix_r[b] <= mem[raddr];
      end
    end

    // A lane with zero weight contributes nothing, whatever its bank entry holds.
    always_ff @(posedge clk) begin
      if (en2) begin
        s2_wgt_r[b] <= wgt_nxt;
      end
      if (en3) begin
        s3_prod_r[b] <= (s2_wgt_r[b] == '0) ? '0 :
                        PROD_W'(s2_wgt_r[b]) * PROD_W'(s2_pix_r[b]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en2) begin
        v2_r <= v1_r && (s1_op_r == OP_COMPUTE);
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_zero_r <= s2_zero_nxt;
    end
    if (en3) begin
      s3_zero_r <= s2_zero_r;
    end
  end

  // Stage 4: sum of the four weighted pixels, truncated, or zero on a border.
  logic [SUM_W-1:0] sum_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;

  assign sum_nxt = SUM_W'(s3_prod_r[0]) + SUM_W'(s3_prod_r[1]) +
                   SUM_W'(s3_prod_r[2]) + SUM_W'(s3_prod_r[3]);
  assign out_pix_nxt = s3_zero_r ? '0 : sum_nxt[2*FRACTION_BITS +: PIX_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en4) begin
      out_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && v3_r) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_chan.valid     = out_v_r;
  assign out_chan.pixel_out = out_pix_r;

`ifndef ASSERT_OFF
  // A compute beat leaving stage 1 always becomes a stage 2 beat.
  a_compute_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && s1_op_r == OP_COMPUTE && en2) |=> v2_r)
    else $error("compute beat lost between stage 1 and stage 2");

  // Loads never reach the result path.
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (en2 && !(v1_r && s1_op_r == OP_COMPUTE)) |=> !v2_r)
    else $error("stage 2 beat appeared without a compute beat");

  // A border beat always delivers zero.
  a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && s3_zero_r && en4) |=> (out_v_r && out_pix_r == '0))
    else $error("border pixel not zero");

  // A stalled result keeps the stages behind it from dropping beats.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_chan.ready && v3_r) |=> (v3_r && $stable(s3_zero_r)))
    else $error("stage 3 beat changed while the output stalled");
`endif

endmodule

[test/tb_grayscale_image_upscaler_core.sv]
// ----------------------------------------------------------------------------
// Grayscale image upscaler core testbench
// Loads source pixels and requests scaled output pixels through the request
// channel, predicts every output pixel from a local copy of the image and
// the registers, and checks the results in order under random stalls on
// both channels, across many register settings and both scaling modes.
// ----------------------------------------------------------------------------
module tb_grayscale_image_upscaler_core;
  timeunit 1ns;
  timeprecision 1ps;
  import giu_pkg::*;

  localparam int SRC_DIM      = 128;
  localparam int OUT_DIM      = 1024;
  localparam int FRAC         = 16;
  localparam longint unsigned ONE = 64'd1 << FRAC;
  localparam int REGION       = 16;
  localparam int PHASE_ITEMS  = 110;
  localparam int RANDOM_ITEMS = 1250;
  localparam int FLUSH_CYCLES = 8;
  localparam int IDLE_PCT     = 8;
  localparam int COORD_MAX    = (1 << OUT_COORD_W) - 1;
  localparam int OUT_DIM_MAX  = (1 << OUT_DIM_W) - 1;
  localparam int STEP_MAX     = (1 << STEP_W) - 1;
  // Index past the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int SEED_PIX [9] = '{0, 255, 17, 128, 64, 200, 1, 254, 90};

  typedef struct packed {
    mode_t                mode;
    logic [SRC_DIM_W-1:0] src_w;
    logic [SRC_DIM_W-1:0] src_h;
    logic [OUT_DIM_W-1:0] out_w;
    logic [OUT_DIM_W-1:0] out_h;
    logic [STEP_W-1:0]    step_x;
    logic [STEP_W-1:0]    step_y;
  } scale_cfg_t;

  typedef struct packed {
    op_t                    op;
    logic [LOAD_COL_W-1:0]  col;
    logic [LOAD_ROW_W-1:0]  row;
    logic [PIX_W-1:0]       value;
    logic [OUT_COORD_W-1:0] ocol;
    logic [OUT_COORD_W-1:0] orow;
  } request_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  request_t              in_beat = '0;
  logic                  out_ready = 1'b0;

  giu_in_if  in_bus ();
  giu_out_if out_bus ();

  assign in_bus.valid       = in_valid;
  assign in_bus.operation   = in_beat.op;
  assign in_bus.load_column = in_beat.col;
  assign in_bus.load_row    = in_beat.row;
  assign in_bus.load_value  = in_beat.value;
  assign in_bus.out_column  = in_beat.ocol;
  assign in_bus.out_row     = in_beat.orow;
  assign out_bus.ready      = out_ready;

  grayscale_image_upscaler_core #(
    .SOURCE_DIM    (SRC_DIM),
    .OUTPUT_DIM    (OUT_DIM),
    .FRACTION_BITS (FRAC)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_bus),
    .out_chan  (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scale_cfg_t       cfg;
  logic [PIX_W-1:0] src_img [SRC_DIM*SRC_DIM];
  bit               loaded [SRC_DIM*SRC_DIM];
  request_t         pending [$];
  logic [PIX_W-1:0] expected_pixels [$];
  logic [PIX_W-1:0] want;
  int               issued = 0;
  int               accepted = 0;
  int               errors = 0;
  bit               steady = 1'b0;
  bit               stale;

  always #5 clk = ~clk;

  function automatic longint unsigned clip(input longint unsigned v, input longint unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // Expected output pixel for one output coordinate. blind is set when the
  // answer depends on a source entry that no queued load has written yet.
  function automatic logic [PIX_W-1:0] scaled_pixel(input scale_cfg_t c,
      input logic [OUT_COORD_W-1:0] ocol, input logic [OUT_COORD_W-1:0] orow,
      output bit blind);
    longint unsigned sw, sh, ow, oh, cx, cy, pos_x, pos_y, px, py;
    longint unsigned fx, fy, gx, gy, acc;
    int a;
    blind = 1'b0;
    sw = clip(c.src_w, SRC_DIM);
    sh = clip(c.src_h, SRC_DIM);
    ow = clip(c.out_w, OUT_DIM);
    oh = clip(c.out_h, OUT_DIM);
    cx = ocol;
    cy = orow;
    pos_x = cx * c.step_x;
    pos_y = cy * c.step_y;
    px = pos_x >> FRAC;
    py = pos_y >> FRAC;
    if (c.mode == MODE_NEAREST) begin
      if (cx >= ow || cy >= oh || px >= sw || py >= sh) return '0;
      a = int'(py * SRC_DIM + px);
      blind = !loaded[a];
      return src_img[a];
    end
    // Bilinear needs the whole 2x2 neighborhood inside both images.
    if (cx + 1 >= ow || cy + 1 >= oh || px + 1 >= sw || py + 1 >= sh) return '0;
    fx = pos_x & (ONE - 1);
    fy = pos_y & (ONE - 1);
    gx = ONE - fx;
    gy = ONE - fy;
    a = int'(py * SRC_DIM + px);
    blind = !(loaded[a] && loaded[a+1] && loaded[a+SRC_DIM] && loaded[a+SRC_DIM+1]);
    acc = gx * gy * src_img[a] + fx * gy * src_img[a+1]
        + gx * fy * src_img[a+SRC_DIM] + fx * fy * src_img[a+SRC_DIM+1];
    return PIX_W'(acc >> (2 * FRAC));
  endfunction

  function automatic scale_cfg_t make_cfg(input mode_t m, input int sw, input int sh,
      input int ow, input int oh, input int sx, input int sy);
    scale_cfg_t c;
    c.mode   = m;
    c.src_w  = SRC_DIM_W'(sw);
    c.src_h  = SRC_DIM_W'(sh);
    c.out_w  = OUT_DIM_W'(ow);
    c.out_h  = OUT_DIM_W'(oh);
    c.step_x = STEP_W'(sx);
    c.step_y = STEP_W'(sy);
    return c;
  endfunction

  function automatic logic [STEP_W-1:0] pick_step();
    case ($urandom_range(3))
      0:       return STEP_W'($urandom_range(65535, 4000));
      1:       return STEP_W'(ONE);
      2:       return STEP_W'($urandom_range(131072, 65537));
      default: return STEP_W'($urandom_range(STEP_MAX));
    endcase
  endfunction

  // Mostly an output size that just covers the source image at this step.
  function automatic logic [OUT_DIM_W-1:0] pick_out_dim(input logic [SRC_DIM_W-1:0] src,
      input logic [STEP_W-1:0] step);
    longint unsigned span;
    if ($urandom_range(99) >= 80) return OUT_DIM_W'($urandom_range(OUT_DIM_MAX));
    span = (clip(src, SRC_DIM) << FRAC) / ((step == 0) ? 1 : step) + $urandom_range(3);
    return OUT_DIM_W'(clip((span == 0) ? 1 : span, OUT_DIM_MAX));
  endfunction

  task automatic push_load(input int col, input int row, input int value);
    request_t q;
    q.op    = OP_LOAD;
    q.col   = LOAD_COL_W'(col);
    q.row   = LOAD_ROW_W'(row);
    q.value = PIX_W'(value);
    q.ocol  = OUT_COORD_W'($urandom);
    q.orow  = OUT_COORD_W'($urandom);
    loaded[row * SRC_DIM + col] = 1'b1;
    pending.push_back(q);
    issued++;
  endtask

  task automatic push_compute(input int ocol, input int orow);
    request_t q;
    q.op    = OP_COMPUTE;
    q.col   = LOAD_COL_W'($urandom);
    q.row   = LOAD_ROW_W'($urandom);
    q.value = PIX_W'($urandom);
    q.ocol  = OUT_COORD_W'(ocol);
    q.orow  = OUT_COORD_W'(orow);
    pending.push_back(q);
    issued++;
  endtask

  // Random output coordinate that never touches an unwritten source entry.
  task automatic push_safe_compute(input int reach_x, input int reach_y);
    logic [OUT_COORD_W-1:0] cx, cy;
    bit blind;
    int tries;
    blind = 1'b1;
    for (tries = 0; tries < 24; tries++) begin
      if ($urandom_range(99) < 15) begin
        cx = OUT_COORD_W'($urandom);
        cy = OUT_COORD_W'($urandom);
      end else if (tries < 16) begin
        cx = OUT_COORD_W'($urandom_range(reach_x));
        cy = OUT_COORD_W'($urandom_range(reach_y));
      end else begin
        cx = OUT_COORD_W'($urandom_range(3));
        cy = OUT_COORD_W'($urandom_range(3));
      end
      void'(scaled_pixel(cfg, cx, cy, blind));
      if (!blind) break;
    end
    // The top-left 3x3 block is loaded first, so the origin is always safe.
    if (blind) begin
      cx = '0;
      cy = '0;
    end
    push_compute(cx, cy);
  endtask

  task automatic settle();
    @(posedge clk);
    while (accepted != issued || expected_pixels.size() != 0) @(posedge clk);
    repeat (FLUSH_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      CFG_MODE:       cfg.mode   = mode_t'(data[0]);
      CFG_SRC_WIDTH:  cfg.src_w  = data[SRC_DIM_W-1:0];
      CFG_SRC_HEIGHT: cfg.src_h  = data[SRC_DIM_W-1:0];
      CFG_OUT_WIDTH:  cfg.out_w  = data[OUT_DIM_W-1:0];
      CFG_OUT_HEIGHT: cfg.out_h  = data[OUT_DIM_W-1:0];
      CFG_STEP_X:     cfg.step_x = data[STEP_W-1:0];
      CFG_STEP_Y:     cfg.step_y = data[STEP_W-1:0];
      default:        ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input scale_cfg_t c, input int n_items, input bit quiet,
      input bit hold_midway);
    longint unsigned span_x, span_y;
    int rw, rh, lw, lh, k, r, col, roll;
    settle();
    write_reg(CFG_MODE, CFG_DATA_W'(c.mode));
    write_reg(CFG_SRC_WIDTH, CFG_DATA_W'(c.src_w));
    write_reg(CFG_SRC_HEIGHT, CFG_DATA_W'(c.src_h));
    write_reg(CFG_OUT_WIDTH, CFG_DATA_W'(c.out_w));
    write_reg(CFG_OUT_HEIGHT, CFG_DATA_W'(c.out_h));
    write_reg(CFG_STEP_X, CFG_DATA_W'(c.step_x));
    write_reg(CFG_STEP_Y, CFG_DATA_W'(c.step_y));
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    steady = quiet;
    rw = int'(clip(clip(c.src_w, SRC_DIM), REGION));
    rh = int'(clip(clip(c.src_h, SRC_DIM), REGION));
    lw = (rw > 0) ? rw : 1;
    lh = (rh > 0) ? rh : 1;
    // Aim most coordinates at the loaded corner of the image and its borders.
    span_x = ((longint'(rw) + 1) << FRAC) / ((c.step_x == 0) ? 1 : c.step_x) + 2;
    span_y = ((longint'(rh) + 1) << FRAC) / ((c.step_y == 0) ? 1 : c.step_y) + 2;
    span_x = clip(clip(span_x, clip(c.out_w, OUT_DIM) + 1), COORD_MAX);
    span_y = clip(clip(span_y, clip(c.out_h, OUT_DIM) + 1), COORD_MAX);
    for (r = 0; r < rh; r++) begin
      for (col = 0; col < rw; col++) begin
        if (!loaded[r * SRC_DIM + col]) push_load(col, r, $urandom_range(255));
      end
    end
    for (k = 0; k < n_items; k++) begin
      if (hold_midway && k == n_items / 2) settle();
      roll = $urandom_range(99);
      if (roll < 65) begin
        push_safe_compute(int'(span_x), int'(span_y));
      end else if (roll < 90) begin
        push_load($urandom_range(lw - 1), $urandom_range(lh - 1), $urandom_range(255));
      end else begin
        push_load($urandom_range(SRC_DIM - 1), $urandom_range(SRC_DIM - 1),
                  $urandom_range(255));
      end
    end
  endtask

  // Request side: present queued beats, and update the image copy or
  // predict the pixel on every accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_bus.ready) begin
        accepted++;
        if (in_beat.op == OP_LOAD) begin
          src_img[{in_beat.row, in_beat.col}] = in_beat.value;
        end else begin
          expected_pixels.push_back(scaled_pixel(cfg, in_beat.ocol, in_beat.orow, stale));
        end
      end
      if (!in_valid || in_bus.ready) begin
        if (pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          in_beat  <= pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t unexpected pixel beat: expected none, got %0d", $time,
                   out_bus.pixel_out);
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_bus.pixel_out !== want) begin
            $display("%0t pixel_out mismatch: expected %0d, got %0d", $time, want,
                     out_bus.pixel_out);
            errors++;
          end
        end
      end
      out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    scale_cfg_t c;
    int phase, first, r, col;
    cfg = make_cfg(MODE_BILINEAR, SRC_DIM_RESET, SRC_DIM_RESET, OUT_DIM_RESET,
                   OUT_DIM_RESET, STEP_RESET, STEP_RESET);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset settings (bilinear, step 0.4).
    for (r = 0; r < 3; r++) begin
      for (col = 0; col < 3; col++) push_load(col, r, SEED_PIX[r * 3 + col]);
    end
    push_load(SRC_DIM - 1, 0, 8'h55);
    push_load(0, SRC_DIM - 1, 8'hAA);
    push_load(SRC_DIM - 1, SRC_DIM - 1, 8'hFF);
    push_compute(0, 0);
    push_compute(3, 1);
    push_compute(4, 4);
    push_compute(1, 2);
    push_compute(OUT_DIM_RESET - 1, 0);   // last output column
    push_compute(248, 0);                 // neighbor column past the source edge
    push_compute(COORD_MAX, COORD_MAX);   // outside the output image
    settle();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_NEAREST));
    push_compute(0, 0);
    push_compute(2, 2);
    push_compute(5, 5);
    push_compute(7, 1);
    push_compute(OUT_DIM_RESET, 0);
    push_compute(COORD_MAX, COORD_MAX);

    first = issued;
    phase = 0;
    while (issued - first < RANDOM_ITEMS) begin
      case (phase)
        0: c = make_cfg(MODE_NEAREST, SRC_DIM, SRC_DIM, OUT_DIM, OUT_DIM, 65536, 65536);
        1: c = make_cfg(MODE_BILINEAR, 255, 255, OUT_DIM_MAX, OUT_DIM_MAX, STEP_MAX, STEP_MAX);
        2: c = make_cfg(MODE_BILINEAR, 1, 1, 1, 1, 1, 1);
        3: c = make_cfg(MODE_NEAREST, 0, 0, 0, 0, 0, 0);
        4: c = make_cfg(MODE_BILINEAR, 2, 2, 2, 2, 131072, 131072);
        default: begin
          c.mode   = mode_t'($urandom_range(1));
          c.src_w  = SRC_DIM_W'(($urandom_range(99) < 85) ? $urandom_range(12, 2)
                                                           : $urandom_range(255));
          c.src_h  = SRC_DIM_W'(($urandom_range(99) < 85) ? $urandom_range(12, 2)
                                                           : $urandom_range(255));
          c.step_x = pick_step();
          c.step_y = pick_step();
          c.out_w  = pick_out_dim(c.src_w, c.step_x);
          c.out_h  = pick_out_dim(c.src_h, c.step_y);
        end
      endcase
      run_phase(c, PHASE_ITEMS, phase == 5, phase == 6);
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
